### hdl/assert_macros.svh
// assertion macros for the rtl files, included by the top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check on the rising clock edge, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check on the rising clock edge, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bpc_pkg.sv
// package for the barometric compensation block: widths, types, rounding helpers
// no dependencies
package bpc_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int PRESS_FRAC = 20;
    localparam int COEF_FRAC  = 52;
    // pipeline depth, one valid bit per datapath stage
    localparam int N_STAGES   = 14;

    localparam logic [1:0] CFG_LOW  = 2'd0;
    localparam logic [1:0] CFG_MID  = 2'd1;
    localparam logic [1:0] CFG_HIGH = 2'd2;

    typedef logic signed [63:0] t_s64;

    typedef struct packed {
        logic [15:0]        t1;
        logic [15:0]        t2;
        logic signed [7:0]  t3;
        logic signed [16:0] p1;
        logic signed [16:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic [15:0]        p5;
        logic [15:0]        p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } t_coef;

    // round a 128-bit product by s bits with ties up, then saturate to 64 bits
    function automatic t_s64 rnd_sat(input logic signed [127:0] x, input int s);
        logic signed [128:0] y;
        logic signed [128:0] z;
        begin
            y = {x[127], x};
            if (s > 0) begin
                y = y + (129'sd1 <<< (s - 1));
            end
            z = y >>> s;
            if (z > 129'sh0_7FFF_FFFF_FFFF_FFFF) begin
                rnd_sat = 64'sh7FFF_FFFF_FFFF_FFFF;
            end else if (z < -129'sh0_8000_0000_0000_0000) begin
                rnd_sat = 64'sh8000_0000_0000_0000;
            end else begin
                rnd_sat = z[63:0];
            end
        end
    endfunction

endpackage

### hdl/bpc_if.sv
// valid/ready channel interfaces for the compensation block
// depends on nothing
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] raw_temperature;
    logic [23:0] raw_pressure;
    modport source (output valid, raw_temperature, raw_pressure, input ready);
    modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] temperature_out;
    logic [23:0]        pressure_out;
    logic               saturated;
    modport source (output valid, temperature_out, pressure_out, saturated, input ready);
    modport sink (input valid, temperature_out, pressure_out, saturated, output ready);
endinterface

### hdl/bpc_coef.sv
// calibration register file and coefficient decode
// depends on bpc_pkg
module bpc_coef
    import bpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output t_coef       o_coef
);

    logic [63:0] r_low, r_mid;
    logic [39:0] r_high;
    logic [167:0] w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_mid  <= '0;
            r_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOW:  r_low  <= i_cfg_data;
                CFG_MID:  r_mid  <= i_cfg_data;
                CFG_HIGH: r_high <= i_cfg_data[39:0];
                default:  ;
            endcase
        end
    end

    assign w_b = {r_high, r_mid, r_low};

    always_comb begin
        o_coef.t1  = w_b[15:0];
        o_coef.t2  = w_b[31:16];
        o_coef.t3  = w_b[39:32];
        o_coef.p1  = {w_b[55], w_b[55:40]} - 17'sd16384;
        o_coef.p2  = {w_b[71], w_b[71:56]} - 17'sd16384;
        o_coef.p3  = w_b[79:72];
        o_coef.p4  = w_b[87:80];
        o_coef.p5  = w_b[103:88];
        o_coef.p6  = w_b[119:104];
        o_coef.p7  = w_b[127:120];
        o_coef.p8  = w_b[135:128];
        o_coef.p9  = w_b[151:136];
        o_coef.p10 = w_b[159:152];
        o_coef.p11 = w_b[167:160];
    end

endmodule

### hdl/bpc_datapath.sv
// pipelined compensation datapath and its two-stage split multiplier
// depends on bpc_pkg
module bpc_mul
    import bpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  t_s64                i_a,
    input  t_s64                i_b,
    output logic signed [127:0] o_p
);

    // 32-bit halves, partial products registered first, then their sum in r_p
    logic [63:0]         r_ll;
    logic signed [64:0]  r_lh;
    logic signed [64:0]  r_hl;
    logic signed [63:0]  r_hh;
    logic signed [127:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[31:0] * i_b[31:0];
            r_lh <= $signed({1'b0, i_a[31:0]}) * $signed(i_b[63:32]);
            r_hl <= $signed(i_a[63:32]) * $signed({1'b0, i_b[31:0]});
            r_hh <= $signed(i_a[63:32]) * $signed(i_b[63:32]);
            r_p  <= $signed({r_hh, 64'd0}) + (128'(r_lh) <<< 32) + (128'(r_hl) <<< 32)
                  + $signed({64'd0, r_ll});
        end
    end

    assign o_p = r_p;

endmodule

module bpc_datapath
    import bpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  t_coef              i_coef,
    input  logic [23:0]        i_rt,
    input  logic [23:0]        i_rp,
    output logic signed [23:0] o_temp,
    output logic [23:0]        o_press,
    output logic               o_sat
);

    // register index k belongs to stage k, the stage of valid bit k-1 in the top level
    logic signed [25:0]            w_d;
    logic signed [42:0]            w_dt2;
    logic signed [59:0]            w_ddt3;
    t_s64                          w_t32;
    logic signed [FRAC_BITS+11:0]  w_tq_n;
    logic signed [FRAC_BITS+19:0]  w_p8tq;
    logic signed [FRAC_BITS+19:0]  w_p4tq;
    logic signed [FRAC_BITS+19:0]  w_p10tq;
    logic signed [49:0]            w_rpsq;
    logic signed [32:0]            w_rpp11;
    logic signed [127:0]           w_pa2, w_pb2, w_po3, w_po4, w_po1, w_pc, w_po2;

    // stage 1..3: temperature front end
    logic signed [25:0] r_d;
    logic signed [51:0] r_dd;
    t_s64               r_t48;
    t_s64               r_tq [3:7];
    logic signed [24:0] r_rp [1:10];
    logic signed [23:0] r_temp [3:N_STAGES];
    logic               r_tsat [3:N_STAGES];
    // stage 4: narrow products
    t_s64 r_a1, r_b1, r_rpsq, r_k3, r_q4;
    // stage 7, 10, 13, 14: rounded horner terms and the final sum
    t_s64 r_a2, r_b2, r_o3, r_o4;
    t_s64 r_o34 [8:10];
    t_s64 r_o1, r_c;
    t_s64 r_s134 [11:12];
    t_s64 r_tot;
    t_s64 r_press;

    assign w_d     = $signed({2'b00, i_rt}) - $signed({2'b00, i_coef.t1, 8'h00});
    assign w_dt2   = r_d * $signed({1'b0, i_coef.t2});
    assign w_ddt3  = r_dd * i_coef.t3;
    assign w_t32   = rnd_sat(128'(r_t48), 32);
    // tq stays below 2^(FRAC_BITS+11) for any calibration
    assign w_tq_n  = r_tq[3][FRAC_BITS+11:0];
    assign w_p8tq  = i_coef.p8 * w_tq_n;
    assign w_p4tq  = i_coef.p4 * w_tq_n;
    assign w_p10tq = i_coef.p10 * w_tq_n;
    assign w_rpsq  = r_rp[3] * r_rp[3];
    assign w_rpp11 = r_rp[3] * i_coef.p11;

    // wide products, each two stages deep
    bpc_mul u_mul_a2 (.i_clk, .i_en, .i_a(r_a1),   .i_b(r_tq[4]), .o_p(w_pa2));
    bpc_mul u_mul_b2 (.i_clk, .i_en, .i_a(r_b1),   .i_b(r_tq[4]), .o_p(w_pb2));
    bpc_mul u_mul_o3 (.i_clk, .i_en, .i_a(r_rpsq), .i_b(r_k3),    .o_p(w_po3));
    bpc_mul u_mul_o4 (.i_clk, .i_en, .i_a(r_rpsq), .i_b(r_q4),    .o_p(w_po4));
    bpc_mul u_mul_o1 (.i_clk, .i_en, .i_a(r_a2),   .i_b(r_tq[7]), .o_p(w_po1));
    bpc_mul u_mul_c  (.i_clk, .i_en, .i_a(r_b2),   .i_b(r_tq[7]), .o_p(w_pc));
    bpc_mul u_mul_o2 (.i_clk, .i_en, .i_a(r_c),    .i_b(64'(r_rp[10])), .o_p(w_po2));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // 1
            r_d     <= w_d;
            r_dd    <= w_d * w_d;
            r_rp[1] <= $signed({1'b0, i_rp});
            // 2
            r_t48   <= (64'(w_dt2) <<< 18) + 64'(w_ddt3);
            // 3
            r_tq[3] <= rnd_sat(128'(r_t48), 48 - FRAC_BITS);
            if (w_t32 > 64'sd8388607) begin
                r_temp[3] <= 24'sh7FFFFF; r_tsat[3] <= 1'b1;
            end else if (w_t32 < -64'sd8388608) begin
                r_temp[3] <= 24'sh800000; r_tsat[3] <= 1'b1;
            end else begin
                r_temp[3] <= w_t32[23:0]; r_tsat[3] <= 1'b0;
            end
            // 4
            r_a1   <= rnd_sat(128'(w_p8tq), 15) + (64'(i_coef.p7) <<< (FRAC_BITS - 8));
            r_b1   <= rnd_sat(128'(w_p4tq), FRAC_BITS + 37 - COEF_FRAC)
                    + (64'(i_coef.p3) <<< (COEF_FRAC - 32));
            r_rpsq <= 64'(w_rpsq);
            r_k3   <= (64'(i_coef.p9) <<< FRAC_BITS) + 64'(w_p10tq);
            r_q4   <= 64'(w_rpp11);
            // 7
            r_a2 <= rnd_sat(w_pa2, FRAC_BITS)
                  + ($signed({48'd0, i_coef.p6}) <<< (FRAC_BITS - 6));
            r_b2 <= rnd_sat(w_pb2, FRAC_BITS) + (64'(i_coef.p2) <<< (COEF_FRAC - 29));
            r_o3 <= rnd_sat(w_po3, FRAC_BITS + 48 - PRESS_FRAC);
            r_o4 <= rnd_sat(w_po4, 65 - PRESS_FRAC);
            // 8
            r_o34[8] <= r_o3 + r_o4;
            // 10
            r_o1 <= rnd_sat(w_po1, 2 * FRAC_BITS - PRESS_FRAC)
                  + ($signed({48'd0, i_coef.p5}) <<< (PRESS_FRAC + 3));
            r_c  <= rnd_sat(w_pc, FRAC_BITS) + (64'(i_coef.p1) <<< (COEF_FRAC - 20));
            // 11
            r_s134[11] <= r_o1 + r_o34[10];
            r_s134[12] <= r_s134[11];
            // 13
            r_tot <= rnd_sat(w_po2, COEF_FRAC - PRESS_FRAC) + r_s134[12];
            // 14
            r_press <= rnd_sat(128'(r_tot), PRESS_FRAC - 6);

            // delay lines
            for (int k = 4; k <= 7; k++) begin
                r_tq[k] <= r_tq[k-1];
            end
            for (int k = 2; k <= 10; k++) begin
                r_rp[k] <= r_rp[k-1];
            end
            for (int k = 9; k <= 10; k++) begin
                r_o34[k] <= r_o34[k-1];
            end
            for (int k = 4; k <= N_STAGES; k++) begin
                r_temp[k] <= r_temp[k-1];
                r_tsat[k] <= r_tsat[k-1];
            end
        end
    end

    always_comb begin
        o_temp = r_temp[N_STAGES];
        o_sat  = r_tsat[N_STAGES];
        if (r_press < 64'sd0) begin
            o_press = '0; o_sat = 1'b1;
        end else if (r_press > 64'sd16777215) begin
            o_press = 24'hFFFFFF; o_sat = 1'b1;
        end else begin
            o_press = r_press[23:0];
        end
    end

endmodule

### hdl/baro_temp_pressure_compensation.sv
// top level of the barometric temperature and pressure compensation block
// depends on bpc_pkg, bpc_if, bpc_coef, bpc_datapath and assert_macros.svh
`include "assert_macros.svh"

// each request carries one raw temperature and one raw pressure conversion and
// yields one compensated temperature (1/65536 degC), pressure (1/64 Pa) and a
// saturation flag; the pipeline is 14 stages deep (N_STAGES) and takes one request
// every cycle while the sink keeps ready high; the depth comes from the temperature
// front end (3 stages), the narrow products (1), the horner chain of wide products,
// each split over two stages plus one stage to round and add its constant, and a
// final rounding stage; a stall holds the whole pipeline in place, with no request
// lost or repeated; calibration must be written over the cfg port only while the
// block is idle, which the block itself does not enforce
module baro_temp_pressure_compensation
    import bpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    bpc_in_if.sink      in_ch,
    bpc_out_if.source   out_ch
);

    t_coef w_coef;
    logic [N_STAGES-1:0] r_vld;
    logic w_en;

    // pipeline advances when the last stage is empty or being drained
    assign w_en = !r_vld[N_STAGES-1] || out_ch.ready;
    assign in_ch.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_STAGES-2:0], in_ch.valid};
        end
    end

    bpc_coef u_coef (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_coef(w_coef)
    );

    bpc_datapath u_dp (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_coef  (w_coef),
        .i_rt    (in_ch.raw_temperature),
        .i_rp    (in_ch.raw_pressure),
        .o_temp  (out_ch.temperature_out),
        .o_press (out_ch.pressure_out),
        .o_sat   (out_ch.saturated)
    );

    assign out_ch.valid = r_vld[N_STAGES-1];

    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(out_ch.pressure_out), "stalled result changed")
    `ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !out_ch.valid, in_ch.ready,
        "input blocked with empty output stage")

endmodule
